// ===== sv/lbbl_pkg.sv =====
package lbbl_pkg;
	localparam int unsigned TIME_W = 64;
	localparam int unsigned LEVEL_W = 8;
	localparam int unsigned PERIOD_W = 24;
	localparam int unsigned COUNT_W = 8;
	localparam int unsigned STEP_W = COUNT_W + 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned BLINK_STEP_US_DEF = 250 * 1000;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_LED_LEVEL = 2'd0;
	localparam cfg_idx_t REG_PULSE_PERIOD = 2'd1;
	localparam cfg_idx_t REG_BLINK_COUNT = 2'd2;
endpackage

// ===== sv/lbbl_if.sv =====
interface lbbl_time_if import lbbl_pkg::*; ();
	logic valid;
	logic ready;
	logic [TIME_W-1:0] time_us;
	modport source (output valid, output time_us, input ready);
	modport sink (input valid, input time_us, output ready);
endinterface

interface lbbl_duty_if import lbbl_pkg::*; ();
	logic valid;
	logic ready;
	logic [LEVEL_W-1:0] duty_level;
	modport source (output valid, output duty_level, input ready);
	modport sink (input valid, input duty_level, output ready);
endinterface

interface lbbl_cfg_if import lbbl_pkg::*; ();
	logic valid;
	logic ready;
	cfg_idx_t index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/led_breathe_blink_level_unit.sv =====
// Path: modulo divider, s1 and s2 registers, quotient divider, output register,
// with one restoring stage per dividend bit in the two divider pipelines.
// Throughput: one request per cycle; the whole pipeline holds while a result waits
// and the output register is full.
// Reset: arst_n clears all valid bits and the three configuration registers to zero.
module led_breathe_blink_level_unit import lbbl_pkg::*; #(
	parameter int unsigned BLINK_STEP_US = BLINK_STEP_US_DEF
) (
	input logic clk,
	input logic arst_n,
	lbbl_time_if.sink stamp,
	lbbl_duty_if.source level,
	lbbl_cfg_if.sink cfg
);
	localparam int unsigned SW = $clog2(BLINK_STEP_US + 1);
	localparam int unsigned CYC_W = SW + STEP_W;
	localparam int unsigned DVW = (CYC_W > PERIOD_W) ? CYC_W : PERIOD_W;
	localparam int unsigned PROD_W = PERIOD_W + LEVEL_W;
	localparam int unsigned QNW = (DVW > PROD_W) ? DVW : PROD_W;
	localparam int unsigned QDW = (SW > PERIOD_W) ? SW : PERIOD_W;
	localparam logic [SW-1:0] STEP_LEN = SW'(BLINK_STEP_US);

	logic [LEVEL_W-1:0]  led_level_q;
	logic [PERIOD_W-1:0] period_q;
	logic [COUNT_W-1:0]  count_q;
	logic                blink;
	logic                breathe;
	logic                en;
	logic [STEP_W-1:0]   cyc_steps;
	logic [DVW-1:0]      div1_d;
	logic                v1;
	logic [DVW-1:0]      r1;
	logic                v_s1;
	logic [DVW-1:0]      r_s1;
	logic [PERIOD_W-1:0] ph_s1;
	logic [PERIOD_W:0]   ph2;
	logic                v_s2;
	logic [QNW-1:0]      dvd_s2;
	logic [QDW-1:0]      div2_d;
	logic                v2;
	logic [STEP_W-1:0]   q2;
	logic [LEVEL_W-1:0]  duty;
	logic                v_out_q;
	logic [LEVEL_W-1:0]  duty_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_level_q <= '0;
			period_q <= '0;
			count_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LED_LEVEL: led_level_q <= cfg.data[LEVEL_W-1:0];
				REG_PULSE_PERIOD: period_q <= cfg.data[PERIOD_W-1:0];
				REG_BLINK_COUNT: count_q <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign blink = count_q != '0;
	assign breathe = period_q != '0;
	assign en = !v_out_q || level.ready;
	assign stamp.ready = en;

	// blink cycle is 2*(count+1) steps
	assign cyc_steps = {(COUNT_W + 1)'(count_q) + 1'b1, 1'b0};
	assign div1_d = blink ? DVW'(CYC_W'(STEP_LEN) * CYC_W'(cyc_steps)) : DVW'(period_q);

	lbbl_div_pipe #(.NW(TIME_W), .DW(DVW), .QW(1)) u_mod (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(stamp.valid), .dividend(stamp.time_us), .divisor(div1_d),
		.out_valid(v1), .rem(r1), .quo()
	);

	assign ph2 = {r1[PERIOD_W-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v1;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r1;
			ph_s1 <= (ph2 >= {1'b0, period_q}) ?
				PERIOD_W'({period_q, 1'b0} - ph2) : ph2[PERIOD_W-1:0];
			dvd_s2 <= blink ? QNW'(r_s1) : QNW'(ph_s1 * PROD_W'(led_level_q));
		end
	end

	assign div2_d = blink ? QDW'(STEP_LEN) : QDW'(period_q);

	lbbl_div_pipe #(.NW(QNW), .DW(QDW), .QW(STEP_W)) u_quo (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s2), .dividend(dvd_s2), .divisor(div2_d),
		.out_valid(v2), .rem(), .quo(q2)
	);

	always_comb begin
		if (blink) begin
			duty = (q2 < STEP_W'({count_q, 1'b0}) && !q2[0]) ? led_level_q : '0;
		end else if (breathe) begin
			duty = q2[LEVEL_W-1:0];
		end else begin
			duty = led_level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			duty_q <= duty;
		end
	end

	assign level.valid = v_out_q;
	assign level.duty_level = duty_q;

	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_out_q |-> duty_q <= led_level_q)
		else $error("duty above peak level");
	a_blink_levels: assert property (@(posedge clk) disable iff (!arst_n)
		v_out_q && blink |-> duty_q == '0 || duty_q == led_level_q)
		else $error("blink level neither dark nor peak");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_out_q && !level.ready |=> v_out_q && $stable(duty_q))
		else $error("result dropped under stall");
endmodule

// ===== sv/lbbl_div_pipe.sv =====
module lbbl_div_pipe #(
	parameter int unsigned NW = 64,
	parameter int unsigned DW = 28,
	parameter int unsigned QW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          out_valid,
	output logic [DW-1:0] rem,
	output logic [QW-1:0] quo
);
	logic          v_s [NW];
	logic [DW-1:0] r_s [NW];
	logic [NW-1:0] n_s [NW];
	logic [QW-1:0] q_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic          pv;
		logic [DW-1:0] pr;
		logic [NW-1:0] pn;
		logic [QW-1:0] pq;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_head
			assign pv = in_valid;
			assign pr = '0;
			assign pn = dividend;
			assign pq = '0;
		end else begin : g_body
			assign pv = v_s[k-1];
			assign pr = r_s[k-1];
			assign pn = n_s[k-1];
			assign pq = q_s[k-1];
		end

		assign trial = {pr, pn[NW-1]};
		assign diff = trial - {1'b0, divisor};
		assign ge = !diff[DW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				n_s[k] <= {pn[NW-2:0], 1'b0};
				q_s[k] <= QW'({pq, ge});
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign rem = r_s[NW-1];
	assign quo = q_s[NW-1];
endmodule
